// ----- src/mi3_pkg.sv -----
// Shared widths, payload types and constants for the 3x3 matrix inverse.
package mi3_pkg;

   // Element format: signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Number of matrix elements / cofactors
   localparam int NUM_ELEM = 9;

   // Intermediate widths, all exact
   localparam int PROD_W = 2 * DATA_WIDTH;        // element * element
   localparam int COF_W  = 2 * DATA_WIDTH + 1;    // p*q - r*s
   localparam int PART_W = 2 * DATA_WIDTH + 1;    // element * half cofactor
   localparam int TERM_W = 3 * DATA_WIDTH + 1;    // element * cofactor
   localparam int DET_W  = 3 * DATA_WIDTH + 3;    // sum of three terms
   localparam int NUM_W  = COF_W + 2 * FRAC_BITS; // |cofactor| scaled by 2^(2F)
   localparam int NUMH_W = NUM_W - DATA_WIDTH;    // numerator above the quotient bits
   localparam int CMP_W  = (NUMH_W > DET_W) ? NUMH_W : DET_W;

   typedef logic signed [DATA_WIDTH-1:0] elem_type;

   typedef struct packed {
      elem_type m00;
      elem_type m01;
      elem_type m02;
      elem_type m10;
      elem_type m11;
      elem_type m12;
      elem_type m20;
      elem_type m21;
      elem_type m22;
   } req_payload_type;

   typedef struct packed {
      elem_type r00;
      elem_type r01;
      elem_type r02;
      elem_type r10;
      elem_type r11;
      elem_type r12;
      elem_type r20;
      elem_type r21;
      elem_type r22;
      logic     singular;
      logic     saturated;
   } rsp_payload_type;

endpackage

// ----- src/mi3_if.sv -----
// Valid/ready stream interfaces for the matrix and result channels.
interface mi3_req_if;
   logic                     valid;
   logic                     ready;
   mi3_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mi3_rsp_if;
   logic                     valid;
   logic                     ready;
   mi3_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/matrix_inverse_3x3.sv -----
// 3x3 fixed-point matrix inverse by adjugate, fully pipelined.
//
//  channel   dir  handshake              contents
//  req_chan  in   valid/ready            m00..m22, one matrix per request
//  rsp_chan  out  valid/ready            r00..r22, singular, saturated
//
// One request enters per cycle while no stall backs up to the input; the restoring
// divider computes one quotient bit per stage for all nine elements.
// Reset (synchronous) clears every stage valid bit; data registers are not reset.
// Each stage has its own ready, so a stalled output holds its result while
// empty stages upstream keep filling; nothing is dropped or repeated.
module matrix_inverse_3x3 (
   input logic       clock,
   input logic       reset,
   mi3_req_if.sink   req_chan,
   mi3_rsp_if.source rsp_chan
);

   localparam int DW   = mi3_pkg::DATA_WIDTH;
   localparam int F    = mi3_pkg::FRAC_BITS;
   localparam int NE   = mi3_pkg::NUM_ELEM;
   localparam int PW   = mi3_pkg::PROD_W;
   localparam int CW   = mi3_pkg::COF_W;
   localparam int LW   = mi3_pkg::PART_W;
   localparam int TW   = mi3_pkg::TERM_W;
   localparam int DTW  = mi3_pkg::DET_W;
   localparam int NW   = mi3_pkg::NUM_W;
   localparam int CMPW = mi3_pkg::CMP_W;

   // Stage map
   localparam int STG_IN   = 0;
   localparam int STG_PROD = 1;
   localparam int STG_COF  = 2;
   localparam int STG_PART = 3;
   localparam int STG_TERM = 4;
   localparam int STG_SUM  = 5;
   localparam int STG_DET  = 6;
   localparam int STG_ABS  = 7;
   localparam int STG_DIV0 = 8;
   localparam int STG_OUT  = STG_DIV0 + DW + 1;
   localparam int NSTG     = STG_OUT + 1;

   // Cofactor k = a[p]*a[q] - a[r]*a[s]
   localparam int COF_IDX [NE][4] = '{
      '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
      '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
      '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
   };

   // Stage valid bits and per-stage ready
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] rdy;
   logic [NSTG-1:0] ld;

   always_comb begin
      rdy[NSTG-1] = ~v_ff[NSTG-1] | rsp_chan.ready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         rdy[s] = ~v_ff[s] | rdy[s+1];
      end
      ld[0] = rdy[0] & req_chan.valid;
      for (int s = 1; s < NSTG; s++) begin
         ld[s] = rdy[s] & v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int s = 1; s < NSTG; s++) begin
            if (rdy[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   assign req_chan.ready = rdy[STG_IN];

   // Stage 0: capture the matrix
   mi3_pkg::elem_type a_in [NE];
   mi3_pkg::elem_type a_ff [NE];

   always_comb begin
      a_in[0] = req_chan.payload.m00;
      a_in[1] = req_chan.payload.m01;
      a_in[2] = req_chan.payload.m02;
      a_in[3] = req_chan.payload.m10;
      a_in[4] = req_chan.payload.m11;
      a_in[5] = req_chan.payload.m12;
      a_in[6] = req_chan.payload.m20;
      a_in[7] = req_chan.payload.m21;
      a_in[8] = req_chan.payload.m22;
   end

   always_ff @(posedge clock) begin
      if (ld[STG_IN]) begin
         a_ff <= a_in;
      end
   end

   // Stage 1: eighteen element products
   logic signed [PW-1:0] prod_in [2*NE];
   logic signed [PW-1:0] prod_ff [2*NE];
   mi3_pkg::elem_type    arow1_ff [3];

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         prod_in[2*k]   = PW'(a_ff[COF_IDX[k][0]]) * PW'(a_ff[COF_IDX[k][1]]);
         prod_in[2*k+1] = PW'(a_ff[COF_IDX[k][2]]) * PW'(a_ff[COF_IDX[k][3]]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_PROD]) begin
         prod_ff  <= prod_in;
         arow1_ff <= a_ff[0:2];
      end
   end

   // Stage 2: cofactors
   logic signed [CW-1:0] cof_in [NE];
   logic signed [CW-1:0] cof2_ff [NE];
   mi3_pkg::elem_type    arow2_ff [3];

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         cof_in[k] = CW'(prod_ff[2*k]) - CW'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_COF]) begin
         cof2_ff  <= cof_in;
         arow2_ff <= arow1_ff;
      end
   end

   // Stage 3: first-row terms split into low and high partial products
   logic signed [LW-1:0] lo_in [3];
   logic signed [LW-1:0] hi_in [3];
   logic signed [LW-1:0] lo_ff [3];
   logic signed [LW-1:0] hi_ff [3];
   logic signed [CW-1:0] cof3_ff [NE];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k] = LW'(arow2_ff[k]) * LW'($signed({1'b0, cof2_ff[k][DW-1:0]}));
         hi_in[k] = LW'(arow2_ff[k]) * LW'($signed(cof2_ff[k][CW-1:DW]));
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_PART]) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         cof3_ff <= cof2_ff;
      end
   end

   // Stage 4: recombine partials into the three terms
   logic signed [TW-1:0] term_in [3];
   logic signed [TW-1:0] term_ff [3];
   logic signed [CW-1:0] cof4_ff [NE];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         term_in[k] = (TW'(hi_ff[k]) <<< DW) + TW'(lo_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_TERM]) begin
         term_ff <= term_in;
         cof4_ff <= cof3_ff;
      end
   end

   // Stage 5: partial determinant sum
   logic signed [TW:0]   sum01_ff;
   logic signed [TW-1:0] term2_ff;
   logic signed [CW-1:0] cof5_ff [NE];

   always_ff @(posedge clock) begin
      if (ld[STG_SUM]) begin
         sum01_ff <= (TW+1)'(term_ff[0]) + (TW+1)'(term_ff[1]);
         term2_ff <= term_ff[2];
         cof5_ff  <= cof4_ff;
      end
   end

   // Stage 6: determinant
   logic signed [DTW-1:0] det_ff;
   logic signed [CW-1:0]  cof6_ff [NE];

   always_ff @(posedge clock) begin
      if (ld[STG_DET]) begin
         det_ff  <= DTW'(sum01_ff) + DTW'(term2_ff);
         cof6_ff <= cof5_ff;
      end
   end

   // Stage 7: magnitudes and quotient signs
   logic [DTW-1:0] dabs_ff;
   logic [CW-1:0]  cabs_ff [NE];
   logic [NE-1:0]  neg7_ff;
   logic           zero7_ff;

   always_ff @(posedge clock) begin
      if (ld[STG_ABS]) begin
         dabs_ff  <= det_ff[DTW-1] ? DTW'(-det_ff) : DTW'(det_ff);
         zero7_ff <= (det_ff == '0);
         for (int k = 0; k < NE; k++) begin
            cabs_ff[k] <= cof6_ff[k][CW-1] ? CW'(-cof6_ff[k]) : CW'(cof6_ff[k]);
            neg7_ff[k] <= cof6_ff[k][CW-1] ^ det_ff[DTW-1];
         end
      end
   end

   // Divider: index 0 is the setup stage, index d holds the state after d steps
   logic [DTW-1:0] rem_ff  [DW+1][NE];
   logic [DW-1:0]  q_ff    [DW+1][NE];
   logic [DW-1:0]  nlo_ff  [DW+1][NE];
   logic [DTW-1:0] den_ff  [DW+1];
   logic [NE-1:0]  neg_ff  [DW+1];
   logic [NE-1:0]  over_ff [DW+1];
   logic           zero_ff [DW+1];

   // Setup: quotient overflows when the numerator's upper part reaches the divisor
   logic [NW-1:0]   num_in  [NE];
   logic [CMPW-1:0] numh_in [NE];
   logic [NE-1:0]   over_in;

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         num_in[k]  = NW'(cabs_ff[k]) << (2 * F);
         numh_in[k] = CMPW'(num_in[k][NW-1:DW]);
         over_in[k] = (numh_in[k] >= CMPW'(dabs_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (ld[STG_DIV0]) begin
         den_ff[0]  <= dabs_ff;
         neg_ff[0]  <= neg7_ff;
         over_ff[0] <= over_in;
         zero_ff[0] <= zero7_ff;
         for (int k = 0; k < NE; k++) begin
            rem_ff[0][k] <= numh_in[k][DTW-1:0];
            nlo_ff[0][k] <= num_in[k][DW-1:0];
            q_ff[0][k]   <= '0;
         end
      end
   end

   // One restoring step per stage
   for (genvar d = 0; d < DW; d++) begin : g_div
      logic [DTW:0]   shf_in  [NE];
      logic [DTW:0]   dif_in  [NE];
      logic [DTW-1:0] rnext_in [NE];
      logic [NE-1:0]  qbit_in;

      always_comb begin
         for (int k = 0; k < NE; k++) begin
            shf_in[k]   = {rem_ff[d][k], nlo_ff[d][k][DW-1]};
            dif_in[k]   = shf_in[k] - {1'b0, den_ff[d]};
            qbit_in[k]  = (shf_in[k] >= {1'b0, den_ff[d]});
            rnext_in[k] = qbit_in[k] ? dif_in[k][DTW-1:0] : shf_in[k][DTW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (ld[STG_DIV0+1+d]) begin
            den_ff[d+1]  <= den_ff[d];
            neg_ff[d+1]  <= neg_ff[d];
            over_ff[d+1] <= over_ff[d];
            zero_ff[d+1] <= zero_ff[d];
            for (int k = 0; k < NE; k++) begin
               rem_ff[d+1][k] <= rnext_in[k];
               nlo_ff[d+1][k] <= nlo_ff[d][k] << 1;
               q_ff[d+1][k]   <= {q_ff[d][k][DW-2:0], qbit_in[k]};
            end
         end
      end
   end

   // Output stage: sign, saturation, singular case
   mi3_pkg::rsp_payload_type rsp_in;
   mi3_pkg::rsp_payload_type rsp_ff;
   logic [DW-1:0]     lim;
   logic [DW-1:0]     mag;
   logic              clip;
   logic              sat;
   mi3_pkg::elem_type res [NE];

   always_comb begin
      sat = 1'b0;
      for (int k = 0; k < NE; k++) begin
         lim  = neg_ff[DW][k] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         clip = over_ff[DW][k] | (q_ff[DW][k] > lim);
         mag  = clip ? lim : q_ff[DW][k];
         res[k] = zero_ff[DW] ? '0 : (neg_ff[DW][k] ? $signed(-mag) : $signed(mag));
         sat  = sat | (clip & ~zero_ff[DW]);
      end
      // inverse(i,j) = cofactor(j,i) / det
      rsp_in.r00       = res[0];
      rsp_in.r01       = res[3];
      rsp_in.r02       = res[6];
      rsp_in.r10       = res[1];
      rsp_in.r11       = res[4];
      rsp_in.r12       = res[7];
      rsp_in.r20       = res[2];
      rsp_in.r21       = res[5];
      rsp_in.r22       = res[8];
      rsp_in.singular  = zero_ff[DW];
      rsp_in.saturated = sat;
   end

   always_ff @(posedge clock) begin
      if (ld[STG_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = v_ff[STG_OUT];
   assign rsp_chan.payload = rsp_ff;

   // Checks
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.singular |->
         !rsp_chan.payload.saturated && rsp_chan.payload.r00 == '0 &&
         rsp_chan.payload.r11 == '0 && rsp_chan.payload.r22 == '0)
      else $error("singular result not cleared");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[STG_IN])
      else $error("accepted request not captured");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[STG_DIV0+1] && !zero_ff[1] && !over_ff[1][0] |->
         rem_ff[1][0] < den_ff[1])
      else $error("divider remainder out of range");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[STG_OUT] && !rsp_chan.ready |->
         !ld[STG_OUT] ##1 v_ff[STG_OUT] && $stable(rsp_ff))
      else $error("stalled result overwritten");

endmodule
